/* rtl/alad_pkg.sv */
// ----------------------------------------------------------------------------
// alad_pkg
// Shared widths, constants, register indexes, the log2 fraction table and
// the log2 helper of the ambient-light auto dimmer.
// ----------------------------------------------------------------------------
`default_nettype none

package alad_pkg;

	localparam int LUX_W   = 24;                 // unsigned Q16.8 lux
	localparam int LEVEL_W = 8;
	localparam int LOG_W   = 13;                 // unsigned Q5.8 log2
	localparam int POS_W   = 5;                  // leading-one position
	localparam int CFG_IDX_W = 3;

	// Moving-average weight 13107/65536 (about 0.2)
	localparam int EMA_W = 14;
	localparam logic [EMA_W-1:0] EMA_WEIGHT = 14'd13107;
	localparam int EMA_SHIFT = 16;
	localparam int ACC_W = LUX_W + EMA_W;
	localparam int STEP_W = ACC_W - EMA_SHIFT;

	localparam logic [1:0] ERROR_RUN_LIMIT = 2'd3;

	// Level division: (2*255*n + d) / (2*d)
	localparam int NUM_W = 22;
	localparam int DEN_W = LOG_W + 1;
	localparam int CNT_W = 5;

	localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

	localparam logic [LUX_W-1:0]   DARK_RESET    = 24'd1280;
	localparam logic [LUX_W-1:0]   BRIGHT_RESET  = 24'd128000;
	localparam logic [LEVEL_W-1:0] DEFAULT_RESET = 8'd128;
	localparam logic [LEVEL_W-1:0] FLOOR_RESET   = 8'd8;
	localparam logic [LEVEL_W-1:0] CEILING_RESET = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DARK_LUX      = 3'd0,
		REG_BRIGHT_LUX    = 3'd1,
		REG_DEFAULT_LEVEL = 3'd2,
		REG_LEVEL_FLOOR   = 3'd3,
		REG_LEVEL_CEILING = 3'd4
	} cfg_reg_t;

	// round(256*log2(1+i/64))
	localparam logic [7:0] LOG_FRAC [64] = '{
		8'd0,   8'd6,   8'd11,  8'd17,  8'd22,  8'd28,  8'd33,  8'd38,
		8'd44,  8'd49,  8'd54,  8'd59,  8'd63,  8'd68,  8'd73,  8'd78,
		8'd82,  8'd87,  8'd92,  8'd96,  8'd100, 8'd105, 8'd109, 8'd113,
		8'd118, 8'd122, 8'd126, 8'd130, 8'd134, 8'd138, 8'd142, 8'd146,
		8'd150, 8'd154, 8'd157, 8'd161, 8'd165, 8'd168, 8'd172, 8'd176,
		8'd179, 8'd183, 8'd186, 8'd190, 8'd193, 8'd197, 8'd200, 8'd203,
		8'd207, 8'd210, 8'd213, 8'd216, 8'd220, 8'd223, 8'd226, 8'd229,
		8'd232, 8'd235, 8'd238, 8'd241, 8'd244, 8'd247, 8'd250, 8'd253
	};

	// Log2 in Q5.8 of a value already shifted left until its leading one
	// sits in the top bit; zero stays zero and reads as log 0.
	function automatic logic [LOG_W-1:0] log_q58(input logic [LUX_W-1:0] norm,
		input logic [POS_W-1:0] shifts);
		logic [POS_W-1:0] pos;
		pos = POS_W'(LUX_W - 1) - shifts;
		if (!norm[LUX_W-1])
			return '0;
		return {pos, LOG_FRAC[norm[LUX_W-2 -: 6]]};
	endfunction

endpackage

`default_nettype wire

/* rtl/ambient_light_auto_dimmer.sv */
// ----------------------------------------------------------------------------
// ambient_light_auto_dimmer
// Smooths ambient-light readings and maps them to a display brightness level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one conversion per request:
//   sensor_error, or a raw_lux reading in unsigned Q16.8. Each request gives
//   exactly one result on the output channel (out_valid/out_ready):
//   brightness_level, sensor_available and smoothed_lux.
//   One request is worked on at a time. After accept, a good reading that
//   moves a seeded average runs the bit-serial multiply and a step to apply
//   it; a check step then picks the level, and where that needs the log
//   mapping the three leading-one shifters run side by side, followed by a
//   lookup step, a divider setup step and the restoring level divider,
//   which equal dark and bright logs skip; a final step ends each request.
//   A new request is taken only once the last has left the final step.
//   The finished result waits in an output register; the next request is
//   taken while it waits. A stalled receiver holds the block only at the
//   final step, until the output register frees.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at the
//   clock edge; the user must make them while the block is idle, as the
//   block does not enforce it. Reset clears the average, the error run and
//   both sensor flags and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ambient_light_auto_dimmer
	import alad_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LUX_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 sensor_error,
	input  wire logic [LUX_W-1:0]     raw_lux,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [LEVEL_W-1:0]        brightness_level,
	output logic                      sensor_available,
	output logic [LUX_W-1:0]          smoothed_lux
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EMA_MUL,
		ST_EMA_APPLY,
		ST_CHECK,
		ST_LOG_NORM,
		ST_LOG_LOOKUP,
		ST_DIV_SETUP,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [LUX_W-1:0]   dark_q, bright_q;
	logic [LEVEL_W-1:0] default_q, floor_q, ceiling_q;

	logic [1:0]       err_run_q;
	logic             avail_q, seeded_q;
	logic [LUX_W-1:0] avg_q;

	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [ACC_W-1:0] mag_q, acc_q;
	logic [EMA_W-1:0] weight_q;

	logic [LUX_W-1:0] norm_a_q, norm_d_q, norm_b_q;
	logic [POS_W-1:0] sh_a_q, sh_d_q, sh_b_q;
	logic [LOG_W-1:0] la_q, ld_q, lb_q;

	logic [NUM_W-1:0] div_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;

	// Combinational helpers
	logic [1:0]         run_next;
	logic [LUX_W-1:0]   diff_mag;
	logic               diff_neg;
	logic [STEP_W-1:0]  step_floor, step_ceil;
	logic [LOG_W-1:0]   n_val, d_val;
	logic [NUM_W-1:0]   num_val;
	logic [DEN_W:0]     rem_sh;
	logic               rem_ge;
	logic [LEVEL_W-1:0] lvl_raw, lvl_fl, lvl_out;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		run_next = (err_run_q < ERROR_RUN_LIMIT) ? err_run_q + 2'd1 : err_run_q;
		diff_neg = raw_lux < avg_q;
		diff_mag = diff_neg ? avg_q - raw_lux : raw_lux - avg_q;

		step_floor = acc_q[ACC_W-1:EMA_SHIFT];
		step_ceil  = step_floor + STEP_W'(|acc_q[EMA_SHIFT-1:0]);

		n_val = (la_q > ld_q) ? la_q - ld_q : '0;
		d_val = (lb_q > ld_q) ? lb_q - ld_q : '0;
		// 510*n + d
		num_val = (NUM_W'(n_val) << 9) - (NUM_W'(n_val) << 1) + NUM_W'(d_val);

		rem_sh = {rem_q, div_q[NUM_W-1]};
		rem_ge = rem_sh >= {1'b0, den_q};

		lvl_raw = (|div_q[NUM_W-1:LEVEL_W]) ? FULL_LEVEL : div_q[LEVEL_W-1:0];
		lvl_fl  = (lvl_raw < floor_q) ? floor_q : lvl_raw;
		lvl_out = (lvl_fl > ceiling_q) ? ceiling_q : lvl_fl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			dark_q           <= DARK_RESET;
			bright_q         <= BRIGHT_RESET;
			default_q        <= DEFAULT_RESET;
			floor_q          <= FLOOR_RESET;
			ceiling_q        <= CEILING_RESET;
			err_run_q        <= '0;
			avail_q          <= 1'b0;
			seeded_q         <= 1'b0;
			avg_q            <= '0;
			cnt_q            <= '0;
			neg_q            <= 1'b0;
			mag_q            <= '0;
			acc_q            <= '0;
			weight_q         <= '0;
			norm_a_q         <= '0;
			norm_d_q         <= '0;
			norm_b_q         <= '0;
			sh_a_q           <= '0;
			sh_d_q           <= '0;
			sh_b_q           <= '0;
			la_q             <= '0;
			ld_q             <= '0;
			lb_q             <= '0;
			div_q            <= '0;
			den_q            <= '0;
			rem_q            <= '0;
			out_valid        <= 1'b0;
			brightness_level <= '0;
			sensor_available <= 1'b0;
			smoothed_lux     <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DARK_LUX:      dark_q    <= cfg_data;
					REG_BRIGHT_LUX:    bright_q  <= cfg_data;
					REG_DEFAULT_LEVEL: default_q <= cfg_data[LEVEL_W-1:0];
					REG_LEVEL_FLOOR:   floor_q   <= cfg_data[LEVEL_W-1:0];
					REG_LEVEL_CEILING: ceiling_q <= cfg_data[LEVEL_W-1:0];
					default: ;
				endcase
			end

			if (out_valid && out_ready && state_q != ST_FINISH)
				out_valid <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (sensor_error) begin
							err_run_q <= run_next;
							if (run_next == ERROR_RUN_LIMIT) begin
								avail_q  <= 1'b0;
								seeded_q <= 1'b0;
							end
							state_q <= ST_CHECK;
						end else begin
							err_run_q <= '0;
							avail_q   <= 1'b1;
							if (!seeded_q) begin
								avg_q    <= raw_lux;
								seeded_q <= 1'b1;
								state_q  <= ST_CHECK;
							end else begin
								neg_q    <= diff_neg;
								mag_q    <= ACC_W'(diff_mag);
								acc_q    <= '0;
								weight_q <= EMA_WEIGHT;
								cnt_q    <= '0;
								state_q  <= ST_EMA_MUL;
							end
						end
					end
				end

				ST_EMA_MUL: begin
					// one weight bit per cycle, LSB first
					if (weight_q[0])
						acc_q <= acc_q + mag_q;
					mag_q    <= mag_q << 1;
					weight_q <= weight_q >> 1;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(EMA_W - 1))
						state_q <= ST_EMA_APPLY;
				end

				ST_EMA_APPLY: begin
					// floor of a negative step rounds away from zero
					if (neg_q)
						avg_q <= avg_q - LUX_W'(step_ceil);
					else
						avg_q <= avg_q + LUX_W'(step_floor);
					state_q <= ST_CHECK;
				end

				ST_CHECK: begin
					if (!avail_q) begin
						div_q   <= NUM_W'(default_q);
						state_q <= ST_FINISH;
					end else if (avg_q <= dark_q) begin
						div_q   <= '0;
						state_q <= ST_FINISH;
					end else if (avg_q >= bright_q) begin
						div_q   <= NUM_W'(FULL_LEVEL);
						state_q <= ST_FINISH;
					end else begin
						norm_a_q <= avg_q;
						norm_d_q <= dark_q;
						norm_b_q <= bright_q;
						sh_a_q   <= '0;
						sh_d_q   <= '0;
						sh_b_q   <= '0;
						cnt_q    <= '0;
						state_q  <= ST_LOG_NORM;
					end
				end

				ST_LOG_NORM: begin
					// advance each value left until its leading one reaches the top
					if (!norm_a_q[LUX_W-1]) begin
						norm_a_q <= norm_a_q << 1;
						sh_a_q   <= sh_a_q + 1'b1;
					end
					if (!norm_d_q[LUX_W-1]) begin
						norm_d_q <= norm_d_q << 1;
						sh_d_q   <= sh_d_q + 1'b1;
					end
					if (!norm_b_q[LUX_W-1]) begin
						norm_b_q <= norm_b_q << 1;
						sh_b_q   <= sh_b_q + 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(LUX_W - 2))
						state_q <= ST_LOG_LOOKUP;
				end

				ST_LOG_LOOKUP: begin
					la_q    <= log_q58(norm_a_q, sh_a_q);
					ld_q    <= log_q58(norm_d_q, sh_d_q);
					lb_q    <= log_q58(norm_b_q, sh_b_q);
					state_q <= ST_DIV_SETUP;
				end

				ST_DIV_SETUP: begin
					if (d_val == '0) begin
						div_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						div_q   <= num_val;
						den_q   <= {d_val, 1'b0};
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIVIDE;
					end
				end

				ST_DIVIDE: begin
					// restoring division: one quotient bit shifts in per cycle
					if (rem_ge)
						rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
					else
						rem_q <= rem_sh[DEN_W-1:0];
					div_q <= {div_q[NUM_W-2:0], rem_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W - 1))
						state_q <= ST_FINISH;
				end

				ST_FINISH: begin
					// hold until the output register frees
					if (!out_valid || out_ready) begin
						out_valid        <= 1'b1;
						brightness_level <= lvl_out;
						sensor_available <= avail_q;
						smoothed_lux     <= avg_q;
						state_q          <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in progress");

	a_run_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		err_run_q <= ERROR_RUN_LIMIT)
		else $error("error run beyond its limit");

	a_seeded_avail: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |-> avail_q)
		else $error("average seeded while sensor unavailable");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOG_LOOKUP) |->
			((norm_a_q[LUX_W-1] || norm_a_q == '0) &&
			 (norm_d_q[LUX_W-1] || norm_d_q == '0) &&
			 (norm_b_q[LUX_W-1] || norm_b_q == '0)))
		else $error("leading-one search incomplete");

endmodule

`default_nettype wire

/* dv/tb_ambient_light_auto_dimmer.sv */
// ----------------------------------------------------------------------------
// tb_ambient_light_auto_dimmer
// Drives ambient-light conversions into the dimmer and checks every result
// over several register settings and idle mixes, against a directed table or
// a bench model of the error run, moving average and log-scale brightness map.
// ----------------------------------------------------------------------------
module tb_ambient_light_auto_dimmer;
	timeunit 1ns;
	timeprecision 1ps;

	import alad_pkg::*;

	localparam int RUN_LIMIT      = 3;
	localparam int AVG_WEIGHT     = 13107;
	localparam int LEVEL_FULL     = 255;
	localparam int RANDOM_PHASES  = 9;
	localparam int PHASE_ITEMS    = 214;
	localparam int STALL_LIMIT    = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DIRECTED_ROWS  = 33;

	localparam int LOG2_FRAC_TBL [64] = '{
		  0,   6,  11,  17,  22,  28,  33,  38,
		 44,  49,  54,  59,  63,  68,  73,  78,
		 82,  87,  92,  96, 100, 105, 109, 113,
		118, 122, 126, 130, 134, 138, 142, 146,
		150, 154, 157, 161, 165, 168, 172, 176,
		179, 183, 186, 190, 193, 197, 200, 203,
		207, 210, 213, 216, 220, 223, 226, 229,
		232, 235, 238, 241, 244, 247, 250, 253
	};

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               avail;
		logic [LUX_W-1:0]   lux;
	} dim_output_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		cfg_reg_t         sel;
		logic             err;
		logic [LUX_W-1:0] value;
		logic             typed;
		dim_output_t      want;
	} dir_row_t;

	localparam dim_output_t NO_WANT = '0;

	// Items carry the conversion; writes carry a register and its value.
	localparam dir_row_t DIR_TABLE [DIRECTED_ROWS] = '{
		// fresh from reset: errors while unavailable give the default level
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b1, '{8'd128, 1'b0, 24'd0}},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b1, '{8'd128, 1'b0, 24'd0}},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b1, '{8'd128, 1'b0, 24'd0}},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b1, '{8'd128, 1'b0, 24'd0}},
		// seed at zero, lifted to the floor
		'{ROW_ITEM,  REG_DARK_LUX,      1'b0, 24'd0,      1'b1, '{8'd8,   1'b1, 24'd0}},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b0, 24'hFFFFFF, 1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b0, 24'hFFFFFF, 1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b0, 24'd0,      1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'hFFFFFF, 1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b0, NO_WANT},
		// reseed exactly at the bright point
		'{ROW_ITEM,  REG_DARK_LUX,      1'b0, 24'd128000, 1'b1, '{8'd255, 1'b1, 24'd128000}},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b0, 24'd10000,  1'b0, NO_WANT},
		// dark and bright share one log value
		'{ROW_WRITE, REG_DARK_LUX,      1'b0, 24'd1024,   1'b0, NO_WANT},
		'{ROW_WRITE, REG_BRIGHT_LUX,    1'b0, 24'd1030,   1'b0, NO_WANT},
		'{ROW_WRITE, REG_LEVEL_FLOOR,   1'b0, 24'd0,      1'b0, NO_WANT},
		'{ROW_WRITE, REG_DEFAULT_LEVEL, 1'b0, 24'd255,    1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b1, '{8'd255, 1'b0, 24'd10000}},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b0, 24'd1027,   1'b1, '{8'd0,   1'b1, 24'd1027}},
		// dark above bright: dark test wins
		'{ROW_WRITE, REG_DARK_LUX,      1'b0, 24'd200000, 1'b0, NO_WANT},
		'{ROW_WRITE, REG_BRIGHT_LUX,    1'b0, 24'd100,    1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b0, 24'd150000, 1'b0, NO_WANT},
		// floor above ceiling: ceiling wins
		'{ROW_WRITE, REG_LEVEL_FLOOR,   1'b0, 24'd200,    1'b0, NO_WANT},
		'{ROW_WRITE, REG_LEVEL_CEILING, 1'b0, 24'd100,    1'b0, NO_WANT},
		'{ROW_WRITE, REG_DEFAULT_LEVEL, 1'b0, 24'd0,      1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b0, NO_WANT},
		'{ROW_ITEM,  REG_DARK_LUX,      1'b1, 24'd0,      1'b0, NO_WANT}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LUX_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 sensor_error;
	logic [LUX_W-1:0]     raw_lux;
	logic                 out_valid;
	logic                 out_ready;
	logic [LEVEL_W-1:0]   brightness_level;
	logic                 sensor_available;
	logic [LUX_W-1:0]     smoothed_lux;

	// dimmer state and registers as the bench sees them
	int unsigned      run_len;
	logic             trusted;
	logic             seeded;
	logic [LUX_W-1:0] avg_lux;
	logic [LUX_W-1:0] cfg_dark;
	logic [LUX_W-1:0] cfg_bright;
	logic [7:0]       cfg_default;
	logic [7:0]       cfg_floor;
	logic [7:0]       cfg_ceiling;

	dim_output_t pending_dims [$];
	int          fail_count;
	int          send_idle;
	int          recv_idle;
	int          hold_req;
	int          stall_cycles;

	ambient_light_auto_dimmer i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sensor_error     (sensor_error),
		.raw_lux          (raw_lux),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.brightness_level (brightness_level),
		.sensor_available (sensor_available),
		.smoothed_lux     (smoothed_lux)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int lux_log2(input logic [LUX_W-1:0] v);
		int p;
		int idx;
		if (v == '0)
			return 0;
		p = LUX_W - 1;
		while (!v[p])
			p--;
		if (p >= 6)
			idx = int'((v >> (p - 6)) & 24'd63);
		else
			idx = int'((v << (6 - p)) & 24'd63);
		return p * 256 + LOG2_FRAC_TBL[idx];
	endfunction

	function automatic int level_for_avg();
		int lvl;
		int ld;
		int la;
		int lb;
		int n;
		int d;
		if (!trusted) begin
			lvl = int'(cfg_default);
		end else if (avg_lux <= cfg_dark) begin
			lvl = 0;
		end else if (avg_lux >= cfg_bright) begin
			lvl = LEVEL_FULL;
		end else begin
			ld = lux_log2(cfg_dark);
			la = lux_log2(avg_lux);
			lb = lux_log2(cfg_bright);
			n = (la > ld) ? la - ld : 0;
			d = (lb > ld) ? lb - ld : 0;
			if (d == 0) begin
				lvl = 0;
			end else begin
				// n*255/d rounded half up
				lvl = (2 * LEVEL_FULL * n + d) / (2 * d);
				if (lvl > LEVEL_FULL)
					lvl = LEVEL_FULL;
			end
		end
		if (lvl < int'(cfg_floor))
			lvl = int'(cfg_floor);
		if (lvl > int'(cfg_ceiling))
			lvl = int'(cfg_ceiling);
		return lvl;
	endfunction

	function automatic dim_output_t next_dim_output(input logic err, input logic [LUX_W-1:0] lux);
		longint      prod;
		dim_output_t res;
		if (err) begin
			if (run_len < RUN_LIMIT)
				run_len++;
			if (run_len == RUN_LIMIT) begin
				trusted = 1'b0;
				seeded = 1'b0;
			end
		end else begin
			run_len = 0;
			if (!seeded) begin
				avg_lux = lux;
				seeded = 1'b1;
			end else begin
				// arithmetic shift of a signed product is an exact floor
				prod = (longint'(lux) - longint'(avg_lux)) * AVG_WEIGHT;
				avg_lux = LUX_W'(longint'(avg_lux) + (prod >>> 16));
			end
			trusted = 1'b1;
		end
		res.level = LEVEL_W'(level_for_avg());
		res.avail = trusted;
		res.lux = avg_lux;
		return res;
	endfunction

	function automatic logic [LUX_W-1:0] spread_lux();
		int p;
		p = $urandom_range(0, LUX_W - 1);
		return LUX_W'((32'd1 << p) | ($urandom & ((32'd1 << p) - 32'd1)));
	endfunction

	function automatic logic [LUX_W-1:0] pick_reading();
		int     r;
		longint v;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 8)
			return '1;
		if (r < 22) begin
			// land on and around the dark and bright points
			v = $urandom_range(0, 1) ? longint'(cfg_bright) : longint'(cfg_dark);
			v = v + longint'($urandom_range(0, 6)) - 3;
			if (v < 0)
				v = 0;
			if (v > longint'(24'hFFFFFF))
				v = longint'(24'hFFFFFF);
			return LUX_W'(v);
		end
		return spread_lux();
	endfunction

	task automatic report_fail(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [LUX_W-1:0] value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = sel;
		cfg_data = value;
		case (sel)
			REG_DARK_LUX: begin
				cfg_dark = value;
			end
			REG_BRIGHT_LUX: begin
				cfg_bright = value;
			end
			REG_DEFAULT_LEVEL: begin
				cfg_default = value[7:0];
			end
			REG_LEVEL_FLOOR: begin
				cfg_floor = value[7:0];
			end
			default: begin
				cfg_ceiling = value[7:0];
			end
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Drop valid and hold until every request has come back.
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_dims.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic send_item(input logic err, input logic [LUX_W-1:0] lux,
		input logic typed, input dim_output_t want);
		dim_output_t pred;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sensor_error = err;
		raw_lux = lux;
		do
			@(posedge clk);
		while (!in_ready);
		pred = next_dim_output(err, lux);
		pending_dims.push_back(typed ? want : pred);
	endtask

	task automatic load_setting(input int k);
		logic [LUX_W-1:0] a;
		logic [LUX_W-1:0] b;
		logic [LUX_W-1:0] t;
		case (k)
			0: begin
				write_reg(REG_DARK_LUX, 24'd1280);
				write_reg(REG_BRIGHT_LUX, 24'd128000);
				write_reg(REG_DEFAULT_LEVEL, 24'd128);
				write_reg(REG_LEVEL_FLOOR, 24'd8);
				write_reg(REG_LEVEL_CEILING, 24'd255);
			end
			1: begin
				write_reg(REG_DARK_LUX, 24'd1);
				write_reg(REG_BRIGHT_LUX, 24'hFFFFFF);
				write_reg(REG_DEFAULT_LEVEL, 24'd0);
				write_reg(REG_LEVEL_FLOOR, 24'd0);
				write_reg(REG_LEVEL_CEILING, 24'd255);
			end
			2: begin
				write_reg(REG_DARK_LUX, 24'hFFFFFF);
				write_reg(REG_BRIGHT_LUX, 24'd1);
				write_reg(REG_DEFAULT_LEVEL, 24'd255);
				write_reg(REG_LEVEL_FLOOR, 24'd255);
				write_reg(REG_LEVEL_CEILING, 24'd0);
			end
			default: begin
				a = spread_lux();
				b = spread_lux();
				// mostly ordered, now and then dark above bright
				if (a > b && $urandom_range(0, 9) != 0) begin
					t = a;
					a = b;
					b = t;
				end
				write_reg(REG_DARK_LUX, a);
				write_reg(REG_BRIGHT_LUX, b);
				write_reg(REG_DEFAULT_LEVEL, LUX_W'($urandom_range(0, 255)));
				if ($urandom_range(0, 5) == 0) begin
					write_reg(REG_LEVEL_FLOOR, LUX_W'($urandom_range(100, 255)));
					write_reg(REG_LEVEL_CEILING, LUX_W'($urandom_range(0, 120)));
				end else begin
					write_reg(REG_LEVEL_FLOOR, LUX_W'($urandom_range(0, 40)));
					write_reg(REG_LEVEL_CEILING, LUX_W'($urandom_range(180, 255)));
				end
			end
		endcase
	endtask

	// receiver: random back-pressure plus one long hold on request
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				n = hold_req;
				hold_req = 0;
				out_ready = 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready = ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// check results and watch for a hung handshake
	always @(posedge clk) begin
		dim_output_t want;
		if (!arst_n) begin
			stall_cycles = 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (out_valid && out_ready) begin
				if (pending_dims.size() == 0) begin
					report_fail($sformatf("result level=%0d lux=%0d with nothing pending",
						brightness_level, smoothed_lux));
				end else begin
					want = pending_dims.pop_front();
					if (brightness_level !== want.level)
						report_fail($sformatf("brightness_level got %0d want %0d",
							brightness_level, want.level));
					if (sensor_available !== want.avail)
						report_fail($sformatf("sensor_available got %0b want %0b",
							sensor_available, want.avail));
					if (smoothed_lux !== want.lux)
						report_fail($sformatf("smoothed_lux got %0d want %0d",
							smoothed_lux, want.lux));
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int  count;
		int  burst;
		bit  held;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sensor_error = 1'b0;
		raw_lux = '0;
		fail_count = 0;
		hold_req = 0;
		send_idle = 27;
		recv_idle = 80;
		held = 1'b0;
		run_len = 0;
		trusted = 1'b0;
		seeded = 1'b0;
		avg_lux = '0;
		cfg_dark = 24'd1280;
		cfg_bright = 24'd128000;
		cfg_default = 8'd128;
		cfg_floor = 8'd8;
		cfg_ceiling = 8'd255;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIR_TABLE[i]) begin
			if (DIR_TABLE[i].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(DIR_TABLE[i].sel, DIR_TABLE[i].value);
			end else begin
				send_item(DIR_TABLE[i].err, DIR_TABLE[i].value, DIR_TABLE[i].typed,
					DIR_TABLE[i].want);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph / 3)
				0: begin
					send_idle = 27;
					recv_idle = 80;
				end
				1: begin
					send_idle = 80;
					recv_idle = 27;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			wait_drained();
			load_setting(ph % 4);
			count = 0;
			while (count < PHASE_ITEMS) begin
				// stall the output while requests keep coming
				if (ph == 6 && !held && count >= 40) begin
					hold_req = HOLD_CYCLES;
					held = 1'b1;
				end
				if ($urandom_range(0, 99) < 10) begin
					// error burst; three in a row reach the run limit
					burst = $urandom_range(1, 4);
					repeat (burst) send_item(1'b1, LUX_W'($urandom), 1'b0, NO_WANT);
					count += burst;
				end else begin
					send_item(1'b0, pick_reading(), 1'b0, NO_WANT);
					count++;
				end
			end
		end

		wait_drained();
		repeat (80) @(posedge clk);
		if (pending_dims.size() != 0)
			report_fail($sformatf("%0d results never arrived", pending_dims.size()));
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
